FILE: src/ssl_pkg.sv
// Shared constants, codes and types for the servo soft-limit controller.
package ssl_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int MAX_REPORTS  = 4;
  localparam int NUM_REPORTS  = (NUM_CHANNELS < MAX_REPORTS) ? NUM_CHANNELS : MAX_REPORTS;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int MODE_W    = 2;
  localparam int ELAPSED_W = 24;
  localparam int CHAN_W    = 2;
  localparam int REQ_W     = 16;
  localparam int SPEED_W   = 15;
  localparam int PULSE_W   = 11;
  localparam int ANGLE_W   = 37;
  localparam int EVENT_W   = 3;
  localparam int LIMIT_W   = 36;
  localparam int GAIN_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int SCALED_W  = ELAPSED_W + GAIN_W;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = SCALED_W + 1;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [REQ_W-1:0] SPEED_MAX  = 16'sd10000;
  localparam logic [PULSE_W-1:0]      PULSE_STOP = 11'd1500;
  // x/20 == (x*3277)>>16 exactly for 0 <= x <= 10000
  localparam logic [MUL_B_W-1:0]      RECIP_20   = 16'd3277;
  localparam int                      RECIP_SHIFT = 16;
  localparam int                      QUOT_W      = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 36'd39600000000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_SET    = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 3'd0,
    EV_STOP_MAX  = 3'd1,
    EV_STOP_MIN  = 3'd2,
    EV_BLOCK_MAX = 3'd3,
    EV_BLOCK_MIN = 3'd4
  } event_t;

endpackage

FILE: src/ssl_mul.sv
// Shared signed multiplier with registered product.
module ssl_mul (
  input  logic                                 clk,
  input  logic signed [ssl_pkg::MUL_A_W-1:0]   op_a,
  input  logic signed [ssl_pkg::MUL_B_W-1:0]   op_b,
  output logic signed [ssl_pkg::MUL_P_W-1:0]   prod_r
);
  import ssl_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

endmodule

FILE: src/servo_soft_limit_controller.sv
// Top level: sequencer, channel state and ports of the servo soft-limit controller.
//
//  channel | ports                                   | direction | beat
//  --------+-----------------------------------------+-----------+-------------------------
//  in      | in_valid/in_ready, mode..speed_request  | input     | one tick or command
//  out     | out_valid/out_ready, report fields      | output    | one channel report
//  cfg     | cfg_valid/cfg_ready, cfg_index/cfg_data | input     | one register write
//
// Steps: each item runs scale and hold once, then multiply, add and clamp per channel,
//   then the set-speed/stop step, then multiply, load and send per report; every angle
//   step and every pulse value goes through the one shared multiplier.
// in_ready is high only in idle; a stall on out holds the current report and the sequencer.
// Reset (synchronous, rst_n low) zeroes all speeds and angles and loads the register defaults.
// cfg_ready is always high; a write goes into its register on the clock edge that sees cfg_valid.
module servo_soft_limit_controller (
  input  logic                                     clk,
  input  logic                                     rst_n,

  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [ssl_pkg::MODE_W-1:0]               in_mode,
  input  logic [ssl_pkg::ELAPSED_W-1:0]            in_elapsed_us,
  input  logic [ssl_pkg::CHAN_W-1:0]               in_channel,
  input  logic signed [ssl_pkg::REQ_W-1:0]         in_speed_request,

  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [ssl_pkg::CHAN_W-1:0]               out_report_channel,
  output logic signed [ssl_pkg::SPEED_W-1:0]       out_speed_now,
  output logic [ssl_pkg::PULSE_W-1:0]              out_pulse_us,
  output logic signed [ssl_pkg::ANGLE_W-1:0]       out_angle_estimate,
  output logic [ssl_pkg::EVENT_W-1:0]              out_limit_event,
  output logic                                     out_last_report,

  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [ssl_pkg::LIMIT_W-1:0]              cfg_data
);
  import ssl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCALE = 10'b0000000010,  // elapsed * gain
    S_HOLD  = 10'b0000000100,  // keep scaled time
    S_MUL   = 10'b0000001000,  // scaled time * speed
    S_ADD   = 10'b0000010000,  // angle + increment
    S_CLAMP = 10'b0000100000,  // limit check and write back
    S_MODE  = 10'b0001000000,  // set-speed / stop
    S_PULSE = 10'b0010000000,  // |speed| * 1/20
    S_LOAD  = 10'b0100000000,  // fill output register
    S_SEND  = 10'b1000000000   // wait for the report beat
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CH_W-1:0]             idx_r, idx_nxt;

  // item fields
  mode_t                       mode_r;
  logic [ELAPSED_W-1:0]        elapsed_r;
  logic [CHAN_W-1:0]           ch_r;
  logic signed [REQ_W-1:0]     req_r;

  // config registers
  logic [LIMIT_W-1:0]          limit_r;
  logic [GAIN_W-1:0]           gain_r;

  // channel state
  logic signed [SPEED_W-1:0]   speed_r [NUM_CHANNELS];
  logic signed [ANGLE_W-1:0]   angle_r [NUM_CHANNELS];
  event_t                      ev_r    [NUM_CHANNELS];

  // datapath
  logic [SCALED_W-1:0]         scaled_r;
  logic signed [MUL_P_W-1:0]   sum_r;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]   mul_p;

  // output register
  logic                        out_valid_r;
  logic [CHAN_W-1:0]           out_ch_r;
  logic signed [SPEED_W-1:0]   out_speed_r;
  logic [PULSE_W-1:0]          out_pulse_r;
  logic signed [ANGLE_W-1:0]   out_angle_r;
  logic [EVENT_W-1:0]          out_event_r;
  logic                        out_last_r;

  logic signed [SPEED_W-1:0]   speed_cur;
  logic signed [ANGLE_W-1:0]   angle_cur;
  logic [SPEED_W-1:0]          speed_mag;
  logic signed [MUL_P_W-1:0]   lim_p, nlim_p;
  logic                        ge_lim, le_nlim, lim_zero;
  logic signed [ANGLE_W:0]     lim_a, nlim_a, sel_angle;
  logic                        at_max, at_min;
  logic signed [REQ_W-1:0]     req_c;
  logic [QUOT_W-1:0]           quot;
  logic [PULSE_W-1:0]          pulse_val;
  logic                        last_ch, last_rep;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  assign out_report_channel = out_ch_r;
  assign out_speed_now      = out_speed_r;
  assign out_pulse_us       = out_pulse_r;
  assign out_angle_estimate = out_angle_r;
  assign out_limit_event    = out_event_r;
  assign out_last_report    = out_last_r;

  assign speed_cur = speed_r[idx_r];
  assign angle_cur = angle_r[idx_r];
  assign speed_mag = speed_cur[SPEED_W-1] ? SPEED_W'(-speed_cur) : SPEED_W'(speed_cur);
  assign last_ch   = (idx_r == CH_W'(NUM_CHANNELS - 1));
  assign last_rep  = (idx_r == CH_W'(NUM_REPORTS - 1));

  // integration limit check on the 45-bit sum
  assign lim_p    = MUL_P_W'($signed({1'b0, limit_r}));
  assign nlim_p   = -lim_p;
  assign ge_lim   = (sum_r >= lim_p);
  assign le_nlim  = (sum_r <= nlim_p);
  assign lim_zero = (limit_r == '0);

  // set-speed: addressed channel's angle against the limit
  assign lim_a  = (ANGLE_W+1)'($signed({1'b0, limit_r}));
  assign nlim_a = -lim_a;
  always_comb begin
    sel_angle = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(ch_r) == i) sel_angle = (ANGLE_W+1)'(angle_r[i]);
    end
  end
  assign at_max = (sel_angle >= lim_a);
  assign at_min = (sel_angle <= nlim_a);

  always_comb begin
    if (req_r > SPEED_MAX)       req_c = SPEED_MAX;
    else if (req_r < -SPEED_MAX) req_c = -SPEED_MAX;
    else                         req_c = req_r;
  end

  // pulse = 1500 +/- trunc(|speed|/20)
  assign quot      = mul_p[RECIP_SHIFT +: QUOT_W];
  assign pulse_val = speed_cur[SPEED_W-1] ? PULSE_STOP - PULSE_W'(quot)
                                          : PULSE_STOP + PULSE_W'(quot);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SCALE: begin
        mul_a = MUL_A_W'(elapsed_r);
        mul_b = MUL_B_W'(gain_r);
      end
      S_MUL: begin
        mul_a = MUL_A_W'(scaled_r);
        mul_b = MUL_B_W'(speed_cur);
      end
      S_PULSE: begin
        mul_a = MUL_A_W'(speed_mag);
        mul_b = RECIP_20;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ssl_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) begin
        state_nxt = S_SCALE;
        idx_nxt   = '0;
      end
      S_SCALE: state_nxt = S_HOLD;
      S_HOLD:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_CLAMP;
      S_CLAMP: begin
        if (last_ch) begin
          state_nxt = S_MODE;
          idx_nxt   = '0;
        end else begin
          state_nxt = S_MUL;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      S_MODE:  state_nxt = S_PULSE;
      S_PULSE: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_SEND;
      S_SEND:  if (out_ready) begin
        if (last_rep) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PULSE;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      gain_r      <= GAIN_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        speed_r[i] <= '0;
        angle_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ANGLE_LIMIT: limit_r <= cfg_data;
          CFG_GAIN:        gain_r  <= cfg_data[GAIN_W-1:0];
          default:         ;
        endcase
      end

      if (state_r == S_LOAD) out_valid_r <= 1'b1;
      else if (state_r == S_SEND && out_ready) out_valid_r <= 1'b0;

      // still channels are neither integrated nor checked
      if (state_r == S_CLAMP && speed_cur != '0) begin
        if (ge_lim && !lim_zero) begin
          angle_r[idx_r] <= ANGLE_W'(lim_p);
          speed_r[idx_r] <= '0;
        end else if (ge_lim || le_nlim) begin
          angle_r[idx_r] <= ANGLE_W'(nlim_p);
          speed_r[idx_r] <= '0;
        end else begin
          angle_r[idx_r] <= ANGLE_W'(sum_r);
        end
      end

      if (state_r == S_MODE) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (mode_r == MODE_STOP) begin
            speed_r[i] <= '0;
          end else if (mode_r == MODE_SET && 32'(ch_r) == i) begin
            if ((at_max && req_c > 0) || (at_min && req_c < 0)) speed_r[i] <= '0;
            else speed_r[i] <= SPEED_W'(req_c);
          end
        end
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      mode_r    <= mode_t'(in_mode);
      elapsed_r <= in_elapsed_us;
      ch_r      <= in_channel;
      req_r     <= in_speed_request;
    end

    if (state_r == S_HOLD) scaled_r <= mul_p[SCALED_W-1:0];
    if (state_r == S_ADD)  sum_r    <= MUL_P_W'(angle_cur) + mul_p;

    if (state_r == S_CLAMP) begin
      if (speed_cur == '0)            ev_r[idx_r] <= EV_NONE;
      else if (ge_lim && !lim_zero)   ev_r[idx_r] <= EV_STOP_MAX;
      else if (ge_lim || le_nlim)     ev_r[idx_r] <= EV_STOP_MIN;
      else                            ev_r[idx_r] <= EV_NONE;
    end

    // a block overrides a stop event from this item
    if (state_r == S_MODE && mode_r == MODE_SET) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (32'(ch_r) == i) begin
          if (at_max && req_c > 0)      ev_r[i] <= EV_BLOCK_MAX;
          else if (at_min && req_c < 0) ev_r[i] <= EV_BLOCK_MIN;
        end
      end
    end

    if (state_r == S_LOAD) begin
      out_ch_r    <= CHAN_W'(idx_r);
      out_speed_r <= speed_cur;
      out_pulse_r <= pulse_val;
      out_angle_r <= angle_cur;
      out_event_r <= ev_r[idx_r];
      out_last_r  <= last_rep;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the servo soft-limit controller: directed limit cases plus random traffic.
module testbench;
  import ssl_pkg::*;

  // Pacing and run limits.
  localparam int     IDLE_BURST_MAX = 17;
  localparam int     SETTLE_CYCLES  = 8;     // quiet time after the reports drain
  localparam int     END_QUIET      = 60;    // quiet time at the end of the run
  localparam int     LONG_HOLD      = 400;   // receiver hold-off that fills the block
  localparam int     WATCHDOG_LIMIT = 2000;  // cycles without any beat on any channel
  localparam longint SPEED_CLAMP    = 10000;
  localparam longint PULSE_FLOOR    = 1000;
  localparam longint PULSE_CEIL     = 2000;

  // One channel report as the block should send it.
  typedef struct packed {
    logic [CHAN_W-1:0]         chan;
    logic signed [SPEED_W-1:0] speed;
    logic [PULSE_W-1:0]        pulse;
    logic signed [ANGLE_W-1:0] angle;
    event_t                    ev;
    logic                      last;
  } chan_report_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  mode_t                       in_mode = MODE_TICK;
  logic [ELAPSED_W-1:0]        in_elapsed_us = '0;
  logic [CHAN_W-1:0]           in_channel = '0;
  logic signed [REQ_W-1:0]     in_speed_request = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [CHAN_W-1:0]           out_report_channel;
  logic signed [SPEED_W-1:0]   out_speed_now;
  logic [PULSE_W-1:0]          out_pulse_us;
  logic signed [ANGLE_W-1:0]   out_angle_estimate;
  logic [EVENT_W-1:0]          out_limit_event;
  logic                        out_last_report;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [LIMIT_W-1:0]          cfg_data = '0;

  // Tracked copy of the channel state and registers, updated on every accepted beat.
  longint             trk_speed [NUM_CHANNELS] = '{default: 0};
  longint             trk_angle [NUM_CHANNELS] = '{default: 0};
  logic [LIMIT_W-1:0] trk_limit = LIMIT_RESET;
  logic [GAIN_W-1:0]  trk_gain  = GAIN_RESET;

  chan_report_t pending_reports[$];

  // Idle control, shared by the sender task and the receiver process.
  bit in_idle_en      = 1'b1;
  bit out_idle_en     = 1'b1;
  int hold_cycles_req = 0;

  int n_items        = 0;
  int n_reports      = 0;
  int n_cfg_writes   = 0;
  int n_errors       = 0;
  int stalled_cycles = 0;

  servo_soft_limit_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_elapsed_us      (in_elapsed_us),
    .in_channel         (in_channel),
    .in_speed_request   (in_speed_request),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_report_channel (out_report_channel),
    .out_speed_now      (out_speed_now),
    .out_pulse_us       (out_pulse_us),
    .out_angle_estimate (out_angle_estimate),
    .out_limit_event    (out_limit_event),
    .out_last_report    (out_last_report),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: integrate moving channels, clamp at the soft limit, apply the
  // command, then queue one report per channel in channel order.
  // ---------------------------------------------------------------------------
  task automatic predict_reports(input mode_t mode, input logic [ELAPSED_W-1:0] elapsed,
                                 input logic [CHAN_W-1:0] chan,
                                 input logic signed [REQ_W-1:0] req);
    event_t       ev [NUM_CHANNELS];
    longint       lim;
    longint       want;
    longint       pulse;
    int           i;
    chan_report_t rep;
    lim = longint'(trk_limit);
    for (i = 0; i < NUM_CHANNELS; i++) begin
      ev[i] = EV_NONE;
      // a still channel is neither integrated nor checked against the limit
      if (trk_speed[i] != 0) begin
        trk_angle[i] += longint'(elapsed) * trk_speed[i] * longint'(trk_gain);
        if (trk_angle[i] >= lim) begin
          trk_angle[i] = lim;
          trk_speed[i] = 0;
          ev[i]        = EV_STOP_MAX;
        end
        // runs after the max check: with a zero limit the min event wins
        if (trk_angle[i] <= -lim) begin
          trk_angle[i] = -lim;
          trk_speed[i] = 0;
          ev[i]        = EV_STOP_MIN;
        end
      end
    end

    case (mode)
      MODE_SET: begin
        if (chan < NUM_CHANNELS) begin
          want = req;
          if (want > SPEED_CLAMP) begin
            want = SPEED_CLAMP;
          end
          if (want < -SPEED_CLAMP) begin
            want = -SPEED_CLAMP;
          end
          // a block overrides a stop event from the same beat
          if (trk_angle[chan] >= lim && want > 0) begin
            want     = 0;
            ev[chan] = EV_BLOCK_MAX;
          end
          if (trk_angle[chan] <= -lim && want < 0) begin
            want     = 0;
            ev[chan] = EV_BLOCK_MIN;
          end
          trk_speed[chan] = want;
        end
      end
      MODE_STOP: begin
        for (i = 0; i < NUM_CHANNELS; i++) begin
          trk_speed[i] = 0;
        end
      end
      default: begin
      end
    endcase

    for (i = 0; i < NUM_REPORTS; i++) begin
      pulse = longint'(PULSE_STOP) + trk_speed[i] / 20;  // truncates toward zero
      if (pulse < PULSE_FLOOR) begin
        pulse = PULSE_FLOOR;
      end
      if (pulse > PULSE_CEIL) begin
        pulse = PULSE_CEIL;
      end
      rep.chan  = i[CHAN_W-1:0];
      rep.speed = trk_speed[i][SPEED_W-1:0];
      rep.pulse = pulse[PULSE_W-1:0];
      rep.angle = trk_angle[i][ANGLE_W-1:0];
      rep.ev    = ev[i];
      rep.last  = (i == NUM_REPORTS - 1);
      pending_reports.push_back(rep);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Valid stays high after a beat so back-to-back beats need only
  // one assignment per time step; gaps lower it first.
  // ---------------------------------------------------------------------------
  task automatic send_item(input mode_t mode, input logic [ELAPSED_W-1:0] elapsed,
                           input logic [CHAN_W-1:0] chan,
                           input logic signed [REQ_W-1:0] req);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, IDLE_BURST_MAX)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_elapsed_us    <= elapsed;
    in_channel       <= chan;
    in_speed_request <= req;
    do @(posedge clk); while (!in_ready);
    predict_reports(mode, elapsed, chan, req);
    n_items++;
  endtask

  // Elapsed times are scaled to the limit so channels usually take a few beats
  // to reach it; a few beats use the full field or zero.
  task automatic send_random_item();
    mode_t                   mode;
    logic [ELAPSED_W-1:0]    elapsed;
    logic signed [REQ_W-1:0] req;
    logic [31:0]             raw;
    longint                  span;
    int                      pick;
    int                      v;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      mode = MODE_SET;
    end else if (pick < 16) begin
      mode = MODE_TICK;
    end else if (pick < 17) begin
      mode = MODE_STOP;
    end else begin
      mode = MODE_STATUS;
    end

    span = longint'(trk_limit) / ((trk_gain == 0 ? 64'sd1 : longint'(trk_gain)) * 60000);
    if (span < 1) begin
      span = 1;
    end
    if (span > 24'h7F_FFFF) begin
      span = 24'h7F_FFFF;
    end
    pick = $urandom_range(0, 19);
    raw  = $urandom();
    if (pick == 0) begin
      elapsed = '0;
    end else if (pick < 3) begin
      elapsed = raw[ELAPSED_W-1:0];
    end else begin
      elapsed = ELAPSED_W'($urandom_range(0, 32'(2 * span)));
    end

    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      v = int'($urandom_range(0, 20000)) - 10000;
    end else if (pick < 16) begin
      v = int'($urandom_range(0, 200)) - 100;
    end else begin
      v = int'($urandom() & 32'hFFFF) - 32768;
    end
    req = v[REQ_W-1:0];
    send_item(mode, elapsed, CHAN_W'($urandom_range(0, NUM_CHANNELS - 1)), req);
  endtask

  // Drop valid and wait until every queued report has been seen.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ANGLE_LIMIT) begin
      trk_limit = data;
    end else begin
      trk_gain = data[GAIN_W-1:0];
    end
    n_cfg_writes++;
  endtask

  // Only called with the block idle. Upper bits of the gain beat are noise.
  task automatic reconfigure(input logic [LIMIT_W-1:0] lim, input logic [GAIN_W-1:0] gain);
    logic [LIMIT_W-1:0] gain_word;
    gain_word = {$urandom(), gain};
    write_reg(CFG_ANGLE_LIMIT, lim);
    write_reg(CFG_GAIN, gain_word);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: clamping, pulse rounding, stop/block at both limits.
  task automatic test_directed_basics();
    send_item(MODE_STATUS, 24'd0, 2'd0, 16'sd0);
    send_item(MODE_TICK, 24'hFF_FFFF, 2'd3, 16'sd0);   // all still: nothing moves
    send_item(MODE_SET, 24'd0, 2'd0, 16'sh7FFF);       // clamps to +10000
    send_item(MODE_SET, 24'd0, 2'd1, 16'sh8000);       // clamps to -10000
    send_item(MODE_SET, 24'd0, 2'd2, 16'sd39);
    send_item(MODE_SET, 24'd0, 2'd3, -16'sd39);
    send_item(MODE_TICK, 24'd1000, 2'd0, 16'sd0);
    send_item(MODE_TICK, 24'hFF_FFFF, 2'd0, 16'sd0);   // ch0/ch1 run into the limits
    send_item(MODE_SET, 24'd0, 2'd0, 16'sd500);        // blocked at max
    send_item(MODE_SET, 24'd0, 2'd1, -16'sd1);         // blocked at min
    send_item(MODE_SET, 24'd0, 2'd2, 16'sd10000);
    send_item(MODE_SET, 24'd0, 2'd3, -16'sd10000);
    // same beat: limit stop during integration, then the set-speed is blocked
    send_item(MODE_SET, 24'hFF_FFFF, 2'd2, 16'sd5000);
    send_item(MODE_SET, 24'hFF_FFFF, 2'd3, -16'sd7);
    send_item(MODE_STOP, 24'd0, 2'd0, 16'sd0);
  endtask

  // Still channels keep angles beyond a newly lowered limit until they move.
  task automatic test_limit_lowered();
    wait_for_reports();
    reconfigure(36'd1_000_000, GAIN_RESET);
    send_item(MODE_SET, 24'd0, 2'd2, 16'sd5);          // >= test blocks it
    send_item(MODE_SET, 24'd0, 2'd2, -16'sd5);         // away from the limit is allowed
    send_item(MODE_TICK, 24'd1, 2'd0, 16'sd0);         // moves, lands on the new limit
    send_item(MODE_SET, 24'd0, 2'd3, -16'sd5);
  endtask

  // Zero limit: a moving channel collapses to 0 with a min stop; both
  // directions are blocked afterwards.
  task automatic test_zero_limit();
    wait_for_reports();
    reconfigure(LIMIT_RESET, GAIN_RESET);
    send_item(MODE_SET, 24'd0, 2'd0, -16'sd200);       // ch0 sits at max, moves away
    send_item(MODE_SET, 24'd0, 2'd1, 16'sd200);        // ch1 sits at min, moves away
    wait_for_reports();
    reconfigure('0, GAIN_RESET);
    send_item(MODE_TICK, 24'd7, 2'd0, 16'sd0);
    send_item(MODE_SET, 24'd0, 2'd2, 16'sd100);
    send_item(MODE_SET, 24'd0, 2'd3, -16'sd100);
  endtask

  // Zero gain: moving channels do not advance but are still checked.
  task automatic test_zero_gain();
    wait_for_reports();
    reconfigure(36'd1_000_000, '0);
    send_item(MODE_SET, 24'd0, 2'd0, 16'sd10000);
    send_item(MODE_TICK, 24'hFF_FFFF, 2'd0, 16'sd0);
    send_item(MODE_STOP, 24'd0, 2'd0, 16'sd0);
  endtask

  task automatic run_random_phase(input int count, input logic [LIMIT_W-1:0] lim,
                                  input logic [GAIN_W-1:0] gain);
    wait_for_reports();
    reconfigure(lim, gain);
    repeat (count) send_random_item();
  endtask

  // Sender stops mid-stream until the block has drained, then resumes.
  task automatic test_pause_until_drained();
    repeat (12) send_random_item();
    wait_for_reports();
    repeat (12) send_random_item();
  endtask

  // Receiver holds off long enough that in_ready drops while beats are offered.
  task automatic test_output_stall();
    hold_cycles_req = LONG_HOLD;
    repeat (20) send_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stall bursts, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : out_pacing
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        stall_left      = hold_cycles_req;
        hold_cycles_req = 0;
      end else if (stall_left == 0 && out_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, IDLE_BURST_MAX);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report checker: every out beat against the oldest pending report.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : report_check
    chan_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report beat with nothing pending (channel %0d)", out_report_channel);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        n_reports++;
        check_field("report_channel", want.chan, out_report_channel);
        check_field("speed_now", want.speed, out_speed_now);
        check_field("pulse_us", want.pulse, out_pulse_us);
        check_field("angle_estimate", want.angle, out_angle_estimate);
        check_field("limit_event", want.ev, out_limit_event);
        check_field("last_report", want.last, out_last_report);
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $error("no beat for %0d cycles, %0d reports pending", WATCHDOG_LIMIT,
             pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed cases, random phases across register
  // settings, pressure tests, then a final phase with no idling at all.
  // ---------------------------------------------------------------------------
  initial begin
    logic [LIMIT_W-1:0] lim_pick;
    logic [GAIN_W-1:0]  gain_pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_limit_lowered();
    test_zero_limit();
    test_zero_gain();

    run_random_phase(70, LIMIT_RESET, GAIN_RESET);
    test_pause_until_drained();
    run_random_phase(60, {LIMIT_W{1'b1}}, 4'd15);          // full-scale limit and gain

    lim_pick = LIMIT_W'($urandom_range(1, 2_000_000));
    run_random_phase(60, lim_pick, 4'd1);                   // tight limit, hits often
    test_output_stall();

    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    lim_pick    = {4'($urandom_range(0, 15)), $urandom()};
    gain_pick   = GAIN_W'($urandom_range(1, 15));
    run_random_phase(50, lim_pick, gain_pick);

    wait_for_reports();
    repeat (END_QUIET) @(posedge clk);

    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      n_errors++;
    end
    $display("Run: %0d input beats (tick/set/stop/status), %0d channel reports checked.",
             n_items, n_reports);
    $display("Run: %0d register writes covering zero, reset and full-scale limit and gain.",
             n_cfg_writes);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
